[rtl/pws_pkg.sv]
// Package for the PWM prescaler and top best-fit search.
// Holds option tables, register indexes and state codes; depends on nothing.
`default_nettype none

package pws_pkg;

  // Ten divisor/mode options; even positions are fast PWM.
  localparam int unsigned OPT_COUNT = 10;
  localparam int unsigned OPT_BITS  = 4;

  // Counter top must be strictly above this value.
  localparam logic [15:0] MIN_TOP_EXCL = 16'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLOCK_HZ  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP_LIMIT = 2'd1;

  // Reset values of the configuration registers.
  localparam int unsigned CLOCK_HZ_RESET  = 1000000;
  localparam logic [15:0] TOP_LIMIT_RESET = 16'd255;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WAIT_Q = 3'd1;
  localparam logic [2:0] ST_OPT    = 3'd2;
  localparam logic [2:0] ST_WAIT_F = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // Log2 of the effective divisor of each option: 1,2,8,16,64,128,256,512,1024,2048.
  function automatic logic [3:0] opt_shift(input logic [OPT_BITS-1:0] idx);
    logic [3:0] s;
    case (idx)
      4'd0:    s = 4'd0;
      4'd1:    s = 4'd1;
      4'd2:    s = 4'd3;
      4'd3:    s = 4'd4;
      4'd4:    s = 4'd6;
      4'd5:    s = 4'd7;
      4'd6:    s = 4'd8;
      4'd7:    s = 4'd9;
      4'd8:    s = 4'd10;
      4'd9:    s = 4'd11;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/pws_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Shared by the search sequencer; depends on no other file.
`default_nettype none

module pws_div #(
  parameter int unsigned W = 26
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);
  localparam int unsigned CNT_BITS = $clog2(W + 1);

  logic [W-1:0]        rem;
  logic [W-1:0]        dvsr;
  logic [CNT_BITS-1:0] cnt;
  logic [W:0]          rem_sh;
  logic [W+1:0]        diff;

  // One trial subtraction per step.
  always_comb begin
    rem_sh = {rem, quotient[W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvsr};
  end

  // Step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= CNT_BITS'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= '0;
      quotient <= dividend;
      dvsr     <= divisor;
    end else if (cnt != '0) begin
      if (!diff[W+1]) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= rem_sh[W-1:0];
      end
      quotient <= {quotient[W-2:0], ~diff[W+1]};
    end
  end

endmodule

`default_nettype wire

[rtl/pwm_setting_best_fit_search.sv]
// Top level of the PWM prescaler and top best-fit search.
// Depends on pws_pkg and the serial divider pws_div.
`default_nettype none

// Usage:
//   Configuration: cfg_valid/cfg_ready transfer cfg_data into register cfg_index
//   (0 clock_hz, 1 top_limit; other indexes are ignored). cfg_ready is always high;
//   write only while busy is low.
//   Request: a transfer happens when start is high and busy is low; target_hz is
//   captured then and busy stays high until the cycle in which done is high.
//   Result: done is high for exactly one cycle with found, prescale, top_value,
//   pwm_fast and achieved_hz valid; the receiver takes it in that cycle and
//   cannot hold it off.
//   Search: one rounded divide for the quotient, then up to ten options, each
//   checked in turn and given a divide for the achieved frequency when it is
//   usable. Both kinds of divide run in the shared serial divider; a zero
//   target skips them and goes straight to the result.
//   Throughput: busy drops in the cycle that shows done, so the next start can
//   transfer at the same edge as the result.
//   Reset: synchronous, active high; clock_hz returns to 1000000, top_limit to
//   255, and the block goes idle.
module pwm_setting_best_fit_search #(
  parameter int unsigned FREQ_BITS = 25
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pws_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [FREQ_BITS-1:0]              cfg_data,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [FREQ_BITS-1:0]              target_hz,
  output logic                                   done,
  output logic                                   found,
  output logic [10:0]                            prescale,
  output logic [15:0]                            top_value,
  output logic                                   pwm_fast,
  output logic [FREQ_BITS-1:0]                   achieved_hz
);
  import pws_pkg::*;

  localparam int unsigned W = FREQ_BITS + 1;

  logic [FREQ_BITS-1:0] clock_hz;
  logic [15:0]          top_limit;
  logic [2:0]           state;
  logic [OPT_BITS-1:0]  idx;
  logic [W-1:0]         q;
  logic [W-1:0]         limit_hz;
  logic [15:0]          cand_top;

  logic                 div_go;
  logic [W-1:0]         div_dividend;
  logic [W-1:0]         div_divisor;
  logic                 div_done;
  logic [W-1:0]         div_quo;

  logic [3:0]           sh;
  logic [W-1:0]         d_full;
  logic [W-1:0]         top_full;
  logic                 opt_fast;
  logic                 opt_end;
  logic                 opt_ok;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz  <= FREQ_BITS'(CLOCK_HZ_RESET);
      top_limit <= TOP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLOCK_HZ:  clock_hz  <= cfg_data;
        REG_TOP_LIMIT: top_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Current option: divisor, top and whether it is usable.
  always_comb begin
    sh       = opt_shift(idx);
    opt_fast = ~idx[0];
    d_full   = W'(1) << sh;
    opt_end  = (idx == OPT_BITS'(OPT_COUNT)) || (q < d_full);
    top_full = (q >> sh) - W'(opt_fast);
    opt_ok   = (top_full > W'(MIN_TOP_EXCL)) && (top_full < W'(top_limit));
  end

  // Divider operand selection.
  always_comb begin
    div_go       = 1'b0;
    div_dividend = W'(clock_hz) >> sh;
    div_divisor  = W'(top_full[15:0]);
    if (state == ST_IDLE) begin
      div_go       = start && (target_hz != '0);
      div_dividend = W'(clock_hz) + W'(target_hz >> 1);
      div_divisor  = W'(target_hz);
    end else if (state == ST_OPT) begin
      div_go = !opt_end && opt_ok;
    end
  end

  pws_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            idx   <= '0;
            state <= (target_hz != '0) ? ST_WAIT_Q : ST_FINISH;
          end
        end
        ST_WAIT_Q: begin
          if (div_done) begin
            state <= ST_OPT;
          end
        end
        ST_OPT: begin
          if (opt_end) begin
            state <= ST_FINISH;
          end else if (opt_ok) begin
            state <= ST_WAIT_F;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_WAIT_F: begin
          if (div_done) begin
            idx   <= idx + 1'b1;
            state <= ST_OPT;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working values and the best option so far.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (state == ST_IDLE && start) begin
      found <= 1'b0;
    end else if (state == ST_WAIT_F && div_done && div_quo < limit_hz) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          limit_hz    <= W'(target_hz) << 1;
          prescale    <= '0;
          top_value   <= '0;
          pwm_fast    <= 1'b0;
          achieved_hz <= '0;
        end
      end
      ST_WAIT_Q: begin
        if (div_done) begin
          q <= div_quo;
        end
      end
      ST_OPT: begin
        cand_top <= top_full[15:0];
      end
      ST_WAIT_F: begin
        if (div_done && div_quo < limit_hz) begin
          limit_hz    <= div_quo;
          achieved_hz <= div_quo[FREQ_BITS-1:0];
          top_value   <= cand_top;
          pwm_fast    <= ~idx[0];
          prescale    <= 11'(1) << opt_shift({idx[OPT_BITS-1:1], 1'b0});
        end
      end
      default: ;
    endcase
  end

  // Checks on the sequencer and the result.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still searching");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && target_hz != '0) |=> busy)
    else $error("accepted request did not start a search");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (prescale == '0 && top_value == '0 && achieved_hz == '0))
    else $error("not-found result carries nonzero fields");

  a_found_top: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (top_value > MIN_TOP_EXCL && prescale != '0))
    else $error("found result with unusable top or prescale");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the PWM prescaler and top best-fit search.
// Depends on pws_pkg and pwm_setting_best_fit_search; predicts each setting
// from its own model of the option search and checks every result transfer.
`default_nettype none

module tb;

  import pws_pkg::*;

  localparam int unsigned FREQ_W = 25;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 3000;
  // Indexes that decode to no register; writes to them must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              found;
    logic [10:0]       prescale;
    logic [15:0]       top_value;
    logic              pwm_fast;
    logic [FREQ_W-1:0] achieved_hz;
  } pwm_setting_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_CLOCK_HZ;
  logic [FREQ_W-1:0]       cfg_data = '0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [FREQ_W-1:0]       target_hz = '0;
  logic                    done;
  logic                    found;
  logic [10:0]             prescale;
  logic [15:0]             top_value;
  logic                    pwm_fast;
  logic [FREQ_W-1:0]       achieved_hz;

  // Shadow copies of the configuration registers.
  logic [FREQ_W-1:0] clock_hz_cfg = FREQ_W'(CLOCK_HZ_RESET);
  logic [15:0]       top_limit_cfg = TOP_LIMIT_RESET;

  pwm_setting_t pending_settings[$];
  pwm_setting_t got_setting;
  pwm_setting_t want_setting;
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  send_idle_pct = 0;

  pwm_setting_best_fit_search #(.FREQ_BITS(FREQ_W)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .target_hz  (target_hz),
    .done       (done),
    .found      (found),
    .prescale   (prescale),
    .top_value  (top_value),
    .pwm_fast   (pwm_fast),
    .achieved_hz(achieved_hz)
  );

  always #1 clk = ~clk;

  // Walk the ten options in order and keep the slowest setting below twice the target.
  function automatic pwm_setting_t best_fit_setting(input logic [FREQ_W-1:0] tgt);
    pwm_setting_t    best;
    longint unsigned clk_l, tgt_l, quot, ceiling, pres, div, top, hz;
    logic            fast, stop;
    best = '0;
    clk_l = 64'(clock_hz_cfg);
    tgt_l = 64'(tgt);
    if (tgt_l != 0) begin
      quot = (clk_l + tgt_l / 2) / tgt_l;
      ceiling = 2 * tgt_l;
      stop = 1'b0;
      for (int k = 0; k < OPT_COUNT; k++) begin
        fast = (k % 2) == 0;
        case (k / 2)
          0:       pres = 1;
          1:       pres = 8;
          2:       pres = 64;
          3:       pres = 256;
          default: pres = 1024;
        endcase
        // Phase-correct counting up and down doubles the divisor.
        div = fast ? pres : 2 * pres;
        if (div > quot) stop = 1'b1;
        if (!stop) begin
          top = quot / div;
          if (fast) top = top - 1;
          if (top > MIN_TOP_EXCL && top < top_limit_cfg) begin
            hz = clk_l / (div * top);
            if (hz < ceiling) begin
              ceiling = hz;
              best.found = 1'b1;
              best.prescale = pres[10:0];
              best.top_value = top[15:0];
              best.pwm_fast = fast;
              best.achieved_hz = hz[FREQ_W-1:0];
            end
          end
        end
      end
    end
    return best;
  endfunction

  // Random target: half the time near a reachable setting, the rest spread or extreme.
  function automatic logic [FREQ_W-1:0] pick_target();
    longint unsigned base, span;
    logic [FREQ_W-1:0] pick;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        span = (top_limit_cfg > 6) ? 64'($urandom_range(5, top_limit_cfg))
                                   : 64'($urandom_range(5, 8));
        base = clock_hz_cfg / ((64'd1 << $urandom_range(0, 11)) * span);
        base = base + 64'($urandom_range(0, 32'(base / 8))) - base / 16;
        pick = base[FREQ_W-1:0];
      end
      5, 6:    pick = FREQ_W'($urandom_range(1, 1000));
      7:       pick = FREQ_W'($urandom);
      8:       pick = FREQ_W'(clock_hz_cfg / $urandom_range(1, 12));
      default: pick = $urandom_range(0, 1) ? {FREQ_W{1'b1}} : FREQ_W'($urandom_range(0, 3));
    endcase
    return pick;
  endfunction

  // Hold the sender off until every expected result has been transferred.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_settings.size() != 0 || busy);
  endtask

  // One request transfer; start stays high so back-to-back requests need no gap.
  task automatic send_target(input logic [FREQ_W-1:0] tgt);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    target_hz <= tgt;
    do @(posedge clk); while (busy);
    pending_settings.push_back(best_fit_setting(tgt));
  endtask

  // Register write, only once the block has gone idle.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [FREQ_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CLOCK_HZ:  clock_hz_cfg = data;
      REG_TOP_LIMIT: top_limit_cfg = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset values of both registers, with targets at the field extremes and in between.
  task automatic test_reset_values();
    send_target('0);
    send_target(25'd1);
    send_target(25'd2);
    send_target(25'd1000);
    send_target(25'd3921);
    send_target({FREQ_W{1'b1}});
  endtask

  // Writes to undecoded indexes must leave both registers alone.
  task automatic test_spare_indexes();
    write_reg(REG_SPARE_A, {FREQ_W{1'b1}});
    write_reg(REG_SPARE_B, '0);
    send_target(25'd1000);
    send_target(25'd5000);
  endtask

  // A zero clock gives a zero quotient, so nothing can be found.
  task automatic test_zero_clock();
    write_reg(REG_CLOCK_HZ, '0);
    send_target(25'd1);
    send_target(25'd1000);
  endtask

  // Top limits at and around the point where the first option becomes usable, and at both ends.
  task automatic test_top_limit_bounds();
    write_reg(REG_CLOCK_HZ, {FREQ_W{1'b1}});
    write_reg(REG_TOP_LIMIT, 25'd5);
    send_target(25'd100000);
    send_target(25'd1000);
    write_reg(REG_TOP_LIMIT, 25'd6);
    send_target(25'd5592405);
    // Upper data bits beyond the register width are dropped.
    write_reg(REG_TOP_LIMIT, {FREQ_W{1'b1}});
    send_target(25'd1);
    send_target(25'd500);
    write_reg(REG_TOP_LIMIT, '0);
    send_target(25'd1000);
  endtask

  // Random traffic in chunks, with a fresh register setting before each chunk.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned items);
    logic [15:0] limit;
    send_idle_pct = idle_pct;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(REG_CLOCK_HZ, FREQ_W'($urandom_range(1, 33554431)));
          1:       write_reg(REG_CLOCK_HZ, FREQ_W'($urandom_range(1, 2000)));
          2:       write_reg(REG_CLOCK_HZ, 25'd1000000);
          3:       write_reg(REG_CLOCK_HZ, 25'd16000000);
          default: write_reg(REG_CLOCK_HZ, {FREQ_W{1'b1}});
        endcase
        case ($urandom_range(0, 4))
          0:       limit = 16'($urandom_range(0, 65535));
          1:       limit = 16'($urandom_range(0, 12));
          2:       limit = TOP_LIMIT_RESET;
          3:       limit = 16'hFFFF;
          default: limit = 16'($urandom_range(6, 1024));
        endcase
        write_reg(REG_TOP_LIMIT, {9'($urandom_range(0, 511)), limit});
        if ($urandom_range(0, 3) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, FREQ_W'($urandom));
      end else if ($urandom_range(0, 29) == 0) begin
        drain_results();
      end
      send_target(pick_target());
    end
  endtask

  // Result checker: every done transfer must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      got_setting = {found, prescale, top_value, pwm_fast, achieved_hz};
      results_seen = results_seen + 1;
      if (pending_settings.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("result %0d arrived with no request outstanding", results_seen);
      end else begin
        want_setting = pending_settings.pop_front();
        if (got_setting !== want_setting) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("result %0d: expected found=%b prescale=%0d top=%0d fast=%b hz=%0d,",
                     results_seen, want_setting.found, want_setting.prescale,
                     want_setting.top_value, want_setting.pwm_fast,
                     want_setting.achieved_hz,
                     " got found=%b prescale=%0d top=%0d fast=%b hz=%0d",
                     got_setting.found, got_setting.prescale,
                     got_setting.top_value, got_setting.pwm_fast,
                     got_setting.achieved_hz);
        end
      end
    end
  end

  // Watchdog on cycles that carry no transfer of any kind.
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_spare_indexes();
    test_zero_clock();
    test_top_limit_bounds();
    test_random_traffic(33, 200);
    test_random_traffic(57, 200);
    test_random_traffic(0, 200);
    drain_results();
    // Leave room for any stray result beyond the longest search.
    repeat (400) @(posedge clk);
    if (mismatch_count == 0 && pending_settings.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

[pwm_setting_best_fit_search.f]
rtl/pws_pkg.sv
rtl/pws_div.sv
rtl/pwm_setting_best_fit_search.sv
tb/sv/tb.sv
